[src/assert_macros.svh]
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// Check a property at every rising edge of ck, ignored while rs is high.
`define ASSERT_CLK(lbl, ck, rs, prop) \
  lbl: assert property (@(posedge ck) disable iff (rs) prop) \
    else $error("assertion failed");
// Check that a condition never holds.
`define ASSERT_NEVER(lbl, ck, rs, cond) \
  lbl: assert property (@(posedge ck) disable iff (rs) !(cond)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_CLK(lbl, ck, rs, prop)
`define ASSERT_NEVER(lbl, ck, rs, cond)
`endif

`endif

[src/cba_pkg.sv]
`default_nettype none

package cba_pkg;

  localparam int BLOCKS             = 128;
  localparam int RESERVED           = 2;
  localparam int DIR_ENTRIES        = 16;
  localparam int ELEMENTS_PER_BLOCK = 5;

  localparam int BLK_W  = $clog2(BLOCKS);
  localparam int DIR_W  = $clog2(DIR_ENTRIES);
  localparam int FREE_W = $clog2(BLOCKS - RESERVED + 1);
  localparam int CNT_W  = 10;
  localparam int NEED_W = $clog2((1023 + ELEMENTS_PER_BLOCK - 1) / ELEMENTS_PER_BLOCK + 1);

  // Reciprocal for an exact floor division of an (CNT_W+1)-bit value
  localparam int RECIP_S = CNT_W + 1 + $clog2(ELEMENTS_PER_BLOCK);
  localparam int RECIP_M = (2 ** RECIP_S + ELEMENTS_PER_BLOCK - 1) / ELEMENTS_PER_BLOCK;
  localparam int PROD_W  = CNT_W + 2 + RECIP_S;

  localparam logic [1:0] OP_ADD    = 2'd0;
  localparam logic [1:0] OP_LOOKUP = 2'd1;
  localparam logic [1:0] OP_DELETE = 2'd2;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_NOSPACE  = 3'd1;
  localparam logic [2:0] ST_TOOLARGE = 3'd2;
  localparam logic [2:0] ST_NOTFOUND = 3'd3;
  localparam logic [2:0] ST_DIRFULL  = 3'd4;

  localparam logic [6:0] MAX_FILE_BLOCKS_RESET = 7'd5;

  typedef struct packed {
    logic [1:0]       operation;
    logic [6:0]       file_id;
    logic [CNT_W-1:0] element_count;
  } cmd_t;

  typedef struct packed {
    logic [2:0]       status;
    logic [6:0]       start_block;
    logic [CNT_W-1:0] file_length;
    logic [6:0]       free_blocks;
  } rsp_t;

  typedef struct packed {
    logic [6:0]       file;
    logic [BLK_W-1:0] start;
    logic [CNT_W-1:0] length;
  } dir_entry_t;

  // Blocks taken by count elements, never fewer than one
  function automatic logic [NEED_W-1:0] blocks_for(input logic [CNT_W-1:0] count);
    logic [CNT_W:0]      x;
    logic [PROD_W-1:0]   prod;
    logic [NEED_W-1:0]   q;
    x    = {1'b0, count} + (CNT_W + 1)'(ELEMENTS_PER_BLOCK - 1);
    prod = PROD_W'(x) * PROD_W'(RECIP_M);
    q    = NEED_W'(prod >> RECIP_S);
    return (q == '0) ? NEED_W'(1) : q;
  endfunction

endpackage

`default_nettype wire

[src/cba_ram.sv]
`default_nettype none

module cba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[src/contiguous_block_allocator.sv]
// First-fit contiguous block allocator. One command word in, one response word out.
// After reset the block bitmap is swept, one block a cycle, with in_stall
// high; cfg writes are taken during that time. A look-up reads the directory slot
// by slot and compares the file id of each live slot. An add checks the free count
// and the size limit, finds the first empty slot, scans the bitmap first-fit past
// the reserved area and marks the file's blocks. The bitmap has a single read port;
// the scan and the marking go one block a cycle. A delete does the look-up and then
// frees the blocks of the file's run, one a cycle. A finished response sits in the
// output register, and the next command is taken while it waits.
`default_nettype none
`include "assert_macros.svh"

module contiguous_block_allocator (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire cba_pkg::cmd_t in_data,
  output logic               out_valid,
  input  wire logic          out_stall,
  output cba_pkg::rsp_t      out_data,
  input  wire logic          cfg_wr_en,
  input  wire logic [6:0]    cfg_wr_data
);
  import cba_pkg::*;

  localparam int CMP_W = (NEED_W > FREE_W) ? ((NEED_W > 7) ? NEED_W : 7)
                                           : ((FREE_W > 7) ? FREE_W : 7);

  localparam logic [3:0] S_INIT = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_CHECK = 4'd2;
  localparam logic [3:0] S_DRD  = 4'd3;
  localparam logic [3:0] S_DCMP = 4'd4;
  localparam logic [3:0] S_FIT  = 4'd5;
  localparam logic [3:0] S_MARK = 4'd6;
  localparam logic [3:0] S_FREE = 4'd7;
  localparam logic [3:0] S_RESP = 4'd8;

  logic [3:0]             state;
  cmd_t                   cmd;
  logic [6:0]             max_file_blocks;
  logic [NEED_W-1:0]      need;
  logic [NEED_W-1:0]      cnt;
  logic [FREE_W-1:0]      free_count;
  logic [DIR_ENTRIES-1:0] dir_valid;
  logic [DIR_W-1:0]       idx;
  logic [BLK_W-1:0]       scan_addr;
  logic                   scan_issue;
  logic                   p_vld;
  logic [BLK_W-1:0]       p_addr;
  logic [BLK_W-1:0]       blk_start;
  logic [CNT_W-1:0]       length_r;
  logic [2:0]             res_status;

  logic                   bm_we;
  logic [BLK_W-1:0]       bm_waddr;
  logic [0:0]             bm_wdata;
  logic [0:0]             bm_rdata;
  logic                   dir_we;
  dir_entry_t             dir_wdata;
  dir_entry_t             dir_rd;
  logic                   free_hit;
  logic                   fit_hit;
  logic                   mark_last;

  cba_ram #(.WIDTH(1), .DEPTH(BLOCKS)) u_bitmap (
    .clk  (clk),
    .we   (bm_we),
    .waddr(bm_waddr),
    .wdata(bm_wdata),
    .raddr(scan_addr),
    .rdata(bm_rdata)
  );

  cba_ram #(.WIDTH($bits(dir_entry_t)), .DEPTH(DIR_ENTRIES)) u_dir (
    .clk  (clk),
    .we   (dir_we),
    .waddr(idx),
    .wdata(dir_wdata),
    .raddr(idx),
    .rdata(dir_rd)
  );

  assign in_stall  = (state != S_IDLE);
  assign free_hit  = (state == S_FREE) && p_vld && bm_rdata[0] &&
                     ({1'b0, p_addr} >= (BLK_W + 1)'(RESERVED));
  assign fit_hit   = p_vld && !bm_rdata[0] && (NEED_W'(cnt + 1'b1) == need);
  assign mark_last = (state == S_MARK) && (cnt == NEED_W'(need - 1'b1));

  assign dir_we    = mark_last;
  assign dir_wdata = '{file: cmd.file_id, start: blk_start, length: cmd.element_count};

  always_comb begin
    bm_we    = 1'b0;
    bm_waddr = p_addr;
    bm_wdata = 1'b0;
    case (state)
      S_INIT: begin
        bm_we    = 1'b1;
        bm_waddr = scan_addr;
        bm_wdata = ({1'b0, scan_addr} < (BLK_W + 1)'(RESERVED));
      end
      S_MARK: begin
        bm_we    = 1'b1;
        bm_waddr = scan_addr;
        bm_wdata = 1'b1;
      end
      S_FREE: begin
        bm_we = free_hit;
      end
      default: begin
        bm_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_INIT;
      scan_addr       <= '0;
      scan_issue      <= 1'b0;
      p_vld           <= 1'b0;
      free_count      <= FREE_W'(BLOCKS - RESERVED);
      dir_valid       <= '0;
      max_file_blocks <= MAX_FILE_BLOCKS_RESET;
      out_valid       <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        max_file_blocks <= cfg_wr_data;
      end
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_INIT: begin
          if (scan_addr == BLK_W'(BLOCKS - 1)) begin
            state <= S_IDLE;
          end else begin
            scan_addr <= scan_addr + 1'b1;
          end
        end

        S_IDLE: begin
          if (in_valid) begin
            cmd  <= in_data;
            need <= blocks_for(in_data.element_count);
            idx  <= '0;
            if (in_data.operation == OP_ADD) begin
              state <= S_CHECK;
            end else if (in_data.operation inside {OP_LOOKUP, OP_DELETE}) begin
              state <= S_DRD;
            end else begin
              res_status <= ST_NOTFOUND;
              state      <= S_RESP;
            end
          end
        end

        S_CHECK: begin
          if (CMP_W'(need) > CMP_W'(free_count)) begin
            res_status <= ST_NOSPACE;
            state      <= S_RESP;
          end else if (CMP_W'(need) > CMP_W'(max_file_blocks)) begin
            res_status <= ST_TOOLARGE;
            state      <= S_RESP;
          end else begin
            state <= S_DRD;
          end
        end

        S_DRD: begin
          if (cmd.operation == OP_ADD) begin
            if (!dir_valid[idx]) begin
              // slot found: start the first-fit scan past the reserved area
              scan_addr  <= BLK_W'(RESERVED);
              scan_issue <= 1'b1;
              p_vld      <= 1'b0;
              cnt        <= '0;
              state      <= S_FIT;
            end else if (idx == DIR_W'(DIR_ENTRIES - 1)) begin
              res_status <= ST_DIRFULL;
              state      <= S_RESP;
            end else begin
              idx <= idx + 1'b1;
            end
          end else if (dir_valid[idx]) begin
            state <= S_DCMP;
          end else if (idx == DIR_W'(DIR_ENTRIES - 1)) begin
            res_status <= ST_NOTFOUND;
            state      <= S_RESP;
          end else begin
            idx <= idx + 1'b1;
          end
        end

        S_DCMP: begin
          if (dir_rd.file == cmd.file_id) begin
            res_status <= ST_OK;
            blk_start  <= dir_rd.start;
            length_r   <= dir_rd.length;
            if (cmd.operation == OP_DELETE) begin
              dir_valid[idx] <= 1'b0;
              need           <= blocks_for(dir_rd.length);
              scan_addr      <= dir_rd.start;
              scan_issue     <= 1'b1;
              p_vld          <= 1'b0;
              cnt            <= '0;
              state          <= S_FREE;
            end else begin
              state <= S_RESP;
            end
          end else if (idx == DIR_W'(DIR_ENTRIES - 1)) begin
            res_status <= ST_NOTFOUND;
            state      <= S_RESP;
          end else begin
            idx   <= idx + 1'b1;
            state <= S_DRD;
          end
        end

        S_FIT: begin
          if (scan_issue) begin
            p_vld  <= 1'b1;
            p_addr <= scan_addr;
            if (scan_addr == BLK_W'(BLOCKS - 1)) begin
              scan_issue <= 1'b0;
            end else begin
              scan_addr <= scan_addr + 1'b1;
            end
          end else begin
            p_vld <= 1'b0;
          end
          if (fit_hit) begin
            // run complete: rewind to its first block and mark from there
            blk_start <= p_addr + 1'b1 - BLK_W'(need);
            scan_addr <= p_addr + 1'b1 - BLK_W'(need);
            cnt       <= '0;
            state     <= S_MARK;
          end else if (p_vld) begin
            cnt <= bm_rdata[0] ? '0 : NEED_W'(cnt + 1'b1);
            if (p_addr == BLK_W'(BLOCKS - 1)) begin
              res_status <= ST_NOSPACE;
              state      <= S_RESP;
            end
          end
        end

        S_MARK: begin
          if (mark_last) begin
            dir_valid[idx] <= 1'b1;
            free_count     <= free_count - FREE_W'(need);
            length_r       <= cmd.element_count;
            res_status     <= ST_OK;
            state          <= S_RESP;
          end else begin
            cnt       <= cnt + 1'b1;
            scan_addr <= scan_addr + 1'b1;
          end
        end

        S_FREE: begin
          if (scan_issue) begin
            p_vld  <= 1'b1;
            p_addr <= scan_addr;
            // stop at the end of the run or the end of the disk
            if (scan_addr == BLK_W'(BLOCKS - 1) || NEED_W'(cnt + 1'b1) == need) begin
              scan_issue <= 1'b0;
            end else begin
              scan_addr <= scan_addr + 1'b1;
              cnt       <= cnt + 1'b1;
            end
          end else begin
            p_vld <= 1'b0;
          end
          if (free_hit) begin
            free_count <= free_count + 1'b1;
          end
          if (!scan_issue && !p_vld) begin
            state <= S_RESP;
          end
        end

        S_RESP: begin
          if (!out_valid || !out_stall) begin
            out_valid            <= 1'b1;
            out_data.status      <= res_status;
            out_data.start_block <= (res_status == ST_OK) ? 7'(blk_start) : 7'd0;
            out_data.file_length <= (res_status == ST_OK) ? length_r : '0;
            out_data.free_blocks <= 7'(free_count);
            state                <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `ASSERT_NEVER(a_free_bound, clk, rst, free_count > FREE_W'(BLOCKS - RESERVED))
  `ASSERT_NEVER(a_run_bound, clk, rst, (state == S_FIT) && (cnt >= need))
  `ASSERT_CLK(a_free_stable, clk, rst, (state != S_MARK && state != S_FREE) |=> $stable(free_count))

endmodule

`default_nettype wire

[dv/contiguous_block_allocator_test.sv]
`timescale 1ns / 100ps

module contiguous_block_allocator_test;
  import cba_pkg::*;

  // the fourth operation code is not defined by the block
  localparam logic [1:0] OP_SPARE = 2'd3;
  localparam int PHASES = 10;
  localparam int PHASE_WORDS = 75;
  localparam int TAIL_CYCLES = 400;

  logic clk = 1'b0;
  logic rst;
  logic in_valid;
  logic in_stall;
  cmd_t in_data;
  logic out_valid;
  logic out_stall;
  rsp_t out_data;
  logic cfg_wr_en;
  logic [6:0] cfg_wr_data;

  int items_sent = 0;

  always #5 clk = ~clk;

  contiguous_block_allocator DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  class alloc_tracker;
    bit         used [BLOCKS];
    bit         live [DIR_ENTRIES];
    logic [6:0] slot_file [DIR_ENTRIES];
    logic [6:0] slot_start [DIR_ENTRIES];
    logic [9:0] slot_len [DIR_ENTRIES];
    int         free_cnt;
    logic [6:0] limit;
    rsp_t       replies_due[$];
    int         errors;

    function new();
      int b;
      int s;
      for (b = 0; b < BLOCKS; b++) used[b] = (b < RESERVED);
      for (s = 0; s < DIR_ENTRIES; s++) live[s] = 1'b0;
      free_cnt = BLOCKS - RESERVED;
      limit = MAX_FILE_BLOCKS_RESET;
      errors = 0;
    endfunction

    // a file of no elements still occupies one block
    function int span(logic [9:0] count);
      int n;
      n = (int'(count) + ELEMENTS_PER_BLOCK - 1) / ELEMENTS_PER_BLOCK;
      return (n == 0) ? 1 : n;
    endfunction

    function void note_cmd(cmd_t c);
      rsp_t r;
      int need;
      int slot;
      int at;
      int run;
      int b;
      int s;
      int lo;
      r.status = ST_NOTFOUND;
      r.start_block = '0;
      r.file_length = '0;
      case (c.operation)
        OP_ADD: begin
          need = span(c.element_count);
          slot = -1;
          for (s = DIR_ENTRIES - 1; s >= 0; s--) if (!live[s]) slot = s;
          at = -1;
          run = 0;
          for (b = RESERVED; b < BLOCKS && at < 0; b++) begin
            run = used[b] ? 0 : run + 1;
            if (run == need) at = b + 1 - need;
          end
          if (need > free_cnt) begin
            r.status = ST_NOSPACE;
          end else if (need > int'(limit)) begin
            r.status = ST_TOOLARGE;
          end else if (slot < 0) begin
            r.status = ST_DIRFULL;
          end else if (at < 0) begin
            r.status = ST_NOSPACE;
          end else begin
            for (b = at; b < at + need; b++) used[b] = 1'b1;
            free_cnt -= need;
            live[slot] = 1'b1;
            slot_file[slot] = c.file_id;
            slot_start[slot] = 7'(at);
            slot_len[slot] = c.element_count;
            r.status = ST_OK;
            r.start_block = 7'(at);
            r.file_length = c.element_count;
          end
        end
        OP_LOOKUP, OP_DELETE: begin
          slot = -1;
          for (s = DIR_ENTRIES - 1; s >= 0; s--)
            if (live[s] && slot_file[s] == c.file_id) slot = s;
          if (slot >= 0) begin
            r.status = ST_OK;
            r.start_block = slot_start[slot];
            r.file_length = slot_len[slot];
            if (c.operation == OP_DELETE) begin
              need = span(slot_len[slot]);
              lo = int'(slot_start[slot]);
              // free only blocks that are really held
              for (b = lo; b < lo + need; b++) begin
                if (b < BLOCKS && b >= RESERVED && used[b]) begin
                  used[b] = 1'b0;
                  free_cnt++;
                end
              end
              live[slot] = 1'b0;
            end
          end
        end
        default: ;
      endcase
      r.free_blocks = 7'(free_cnt);
      replies_due.push_back(r);
    endfunction

    function void compare(string what, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
        errors++;
      end
    endfunction

    function void check_reply(rsp_t got);
      rsp_t want;
      if (replies_due.size() == 0) begin
        $display("%0t: unexpected reply word, expected none, actual %h", $time, got);
        errors++;
        return;
      end
      want = replies_due.pop_front();
      compare("status", 16'(want.status), 16'(got.status));
      compare("start_block", 16'(want.start_block), 16'(got.start_block));
      compare("file_length", 16'(want.file_length), 16'(got.file_length));
      compare("free_blocks", 16'(want.free_blocks), 16'(got.free_blocks));
    endfunction

    function int live_id();
      int ids[$];
      int s;
      for (s = 0; s < DIR_ENTRIES; s++) if (live[s]) ids.push_back(int'(slot_file[s]));
      if (ids.size() == 0) return -1;
      return ids[$urandom_range(0, ids.size() - 1)];
    endfunction
  endclass

  alloc_tracker board = new();

  // mostly short gaps, now and then a long one; none at all in calm stretches
  function automatic int pick_gap(bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic cmd_t make_cmd(logic [1:0] op, logic [6:0] id, logic [9:0] count);
    cmd_t c;
    c.operation = op;
    c.file_id = id;
    c.element_count = count;
    return c;
  endfunction

  function automatic cmd_t random_cmd();
    cmd_t c;
    int r;
    int id;
    int top;
    c.operation = OP_SPARE;
    c.file_id = 7'($urandom_range(0, 127));
    c.element_count = 10'($urandom_range(0, 1023));
    top = (board.limit == 0) ? ELEMENTS_PER_BLOCK : ELEMENTS_PER_BLOCK * int'(board.limit);
    r = $urandom_range(0, 99);
    if (r < 45) begin
      c.operation = OP_ADD;
      // a small pool of names makes duplicates common
      if ($urandom_range(0, 9) < 7) c.file_id = 7'($urandom_range(1, 20));
      r = $urandom_range(0, 99);
      if (r < 55) c.element_count = 10'($urandom_range(1, top));
      else if (r < 70) c.element_count = 10'($urandom_range(0, 10));
      else if (r < 85) c.element_count = 10'(top - 4 + $urandom_range(0, 9));
    end else if (r < 95) begin
      c.operation = (r < 70) ? OP_LOOKUP : OP_DELETE;
      id = board.live_id();
      if (id >= 0 && $urandom_range(0, 9) < 8) c.file_id = 7'(id);
    end
    return c;
  endfunction

  task automatic send_cmd(input cmd_t c);
    int gap;
    gap = pick_gap((items_sent / 60) % 4 == 1);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= c;
    do @(posedge clk); while (in_stall);
    board.note_cmd(c);
    items_sent++;
  endtask

  // drain every outstanding reply, then write the register
  task automatic set_limit(input logic [6:0] v);
    in_valid <= 1'b0;
    while (board.replies_due.size() != 0) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    board.limit = v;
  endtask

  initial begin : reply_side
    int stall_left;
    int cyc;
    bit calm;
    out_stall = 1'b0;
    stall_left = 0;
    cyc = 0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) board.check_reply(out_data);
      cyc++;
      calm = ((cyc / 700) % 4 == 2);
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
        stall_left = pick_gap(calm);
      end
    end
  end

  initial begin : command_side
    logic [6:0] phase_limit [PHASES];
    int p;
    int k;
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    phase_limit = '{7'd1, 7'd126, 7'd5, 7'd127, 7'd0, 7'd3, 7'd60, 7'd126, 7'd10, 7'd5};
    phase_limit[6] = 7'($urandom_range(1, 126));
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // register still at its reset value
    send_cmd(make_cmd(OP_ADD, 7'd1, 10'd0));
    send_cmd(make_cmd(OP_ADD, 7'd2, 10'd25));
    send_cmd(make_cmd(OP_ADD, 7'd3, 10'd26));
    send_cmd(make_cmd(OP_ADD, 7'd127, 10'd1));
    send_cmd(make_cmd(OP_ADD, 7'd0, 10'd5));
    send_cmd(make_cmd(OP_ADD, 7'd1, 10'd3));
    send_cmd(make_cmd(OP_LOOKUP, 7'd1, 10'd0));
    send_cmd(make_cmd(OP_LOOKUP, 7'd0, 10'd1023));
    send_cmd(make_cmd(OP_LOOKUP, 7'd99, 10'd0));
    send_cmd(make_cmd(OP_DELETE, 7'd1, 10'd0));
    send_cmd(make_cmd(OP_LOOKUP, 7'd1, 10'd0));
    send_cmd(make_cmd(OP_SPARE, 7'd2, 10'd1023));
    send_cmd(make_cmd(OP_DELETE, 7'd55, 10'd0));
    send_cmd(make_cmd(OP_ADD, 7'd4, 10'd1023));
    send_cmd(make_cmd(OP_ADD, 7'd5, 10'd1));
    set_limit(7'd0);
    send_cmd(make_cmd(OP_ADD, 7'd6, 10'd1));
    send_cmd(make_cmd(OP_DELETE, 7'd127, 10'd0));
    set_limit(7'd127);
    send_cmd(make_cmd(OP_ADD, 7'd64, 10'd500));
    send_cmd(make_cmd(OP_ADD, 7'd65, 10'd100));
    send_cmd(make_cmd(OP_LOOKUP, 7'd64, 10'd0));
    send_cmd(make_cmd(OP_DELETE, 7'd64, 10'd0));
    send_cmd(make_cmd(OP_DELETE, 7'd2, 10'd0));

    for (p = 0; p < PHASES; p++) begin
      set_limit(phase_limit[p]);
      for (k = 0; k < PHASE_WORDS; k++) send_cmd(random_cmd());
    end

    in_valid <= 1'b0;
    while (board.replies_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (board.errors == 0 && board.replies_due.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #15_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
